@@ rtl/dsp_mailbox_command_responder_unit_macros.svh @@
// Assertion macros shared by the mailbox responder RTL.
`ifndef DSP_MAILBOX_COMMAND_RESPONDER_UNIT_MACROS_SVH
`define DSP_MAILBOX_COMMAND_RESPONDER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define DMCR_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define DMCR_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DMCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DMCR_ASSERT_ALWAYS(label, expr, msg)
`define DMCR_ASSERT_IMPLIES(label, ante, cons, msg)
`define DMCR_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/dmcr_pkg.sv @@
// Types, mail constants and command codes of the mailbox responder.
package dmcr_pkg;

  typedef enum logic [1:0] {
    MODE_SEND  = 2'd0,
    MODE_RD_HI = 2'd1,
    MODE_RD_LO = 2'd2,
    MODE_TICK  = 2'd3
  } mode_t;

  // Reply mails
  localparam logic [31:0] MAIL_INIT   = 32'hDCD1_0000;
  localparam logic [31:0] MAIL_RESUME = 32'hDCD1_0001;
  localparam logic [31:0] MAIL_SYNC   = 32'hDCD1_0004;
  localparam logic [31:0] SYNC_TAG    = 32'hF355_0000;

  // Greeting words held by the reply queue out of reset
  localparam logic [31:0] GREET_0     = 32'h0000_0000;
  localparam logic [31:0] GREET_1     = 32'h8054_4348;
  localparam logic [31:0] GREET_2     = 32'h8071_FEED;
  localparam int          GREET_WORDS = 3;

  // Upper-half command prefixes
  localparam logic [15:0] HI_NONE   = 16'h0000;
  localparam logic [15:0] HI_RESUME = 16'hBABE;
  localparam logic [15:0] HI_TEST   = 16'hCDD1;

  // Lower-half command forms
  localparam logic [15:0] CMD_RESUME_NOW = 16'h0000;
  localparam logic [15:0] CMD_RESUME_4   = 16'h0040;
  localparam logic [15:0] CMD_SYNC_A     = 16'h000A;
  localparam logic [15:0] CMD_SYNC_B     = 16'h3800;
  localparam logic [15:0] CMD_SYNC_C     = 16'h5999;
  localparam logic [15:0] CMD_SYNC_D     = 16'h5FFB;
  localparam logic [15:0] CMD_SYNC_E     = 16'h2000;
  localparam logic [15:0] CMD_SYNC_F     = 16'h4000;
  localparam logic [15:0] CMD_VEC_A      = 16'hA001;
  localparam logic [15:0] CMD_VEC_B      = 16'hC002;
  localparam logic [15:0] CMD_VEC_C      = 16'hA002;
  localparam logic [15:0] CMD_VEC_D      = 16'hB002;
  localparam logic [15:0] CMD_BOOT       = 16'hD001;

  // Parameter counts implied by the command forms
  localparam logic [15:0] PARAMS_RESUME = 16'd1;
  localparam logic [15:0] PARAMS_TEST   = 16'd10;
  localparam logic [15:0] PARAMS_SYNC   = 16'd2;
  localparam logic [15:0] PARAMS_RES4   = 16'd4;

  function automatic logic [31:0] greet_word(input logic [1:0] idx);
    logic [31:0] w;
    case (idx)
      2'd0:    w = GREET_0;
      2'd1:    w = GREET_1;
      2'd2:    w = GREET_2;
      default: w = GREET_0;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/dsp_mailbox_command_responder_unit.sv @@
// Mailbox command responder: command decode, reply queue and read-out.
// Beats pass from the input register, through decode and queue update, into the
//   result register.
// Throughput: one beat per cycle unless out_ready stalls; the reply queue has two banks
//   split by slot parity, so the two pushes of one command land in the same cycle.
// Reset (rst_n low at a clock edge, synchronous) empties both stages, clears
//   the command state and leaves the three greeting words queued.
`include "dsp_mailbox_command_responder_unit_macros.svh"

module dsp_mailbox_command_responder_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_mail_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_read_data,
  output logic        out_raise_interrupt,
  output logic        out_overflow,
  output logic        out_booted,
  output logic        out_replies_waiting
);
  import dmcr_pkg::*;

  // Queue geometry: slots run modulo a power of two at least QUEUE_DEPTH,
  // the queue holds at most QUEUE_DEPTH-1 words, counted in cnt_r.
  localparam int             PW      = $clog2(QUEUE_DEPTH);
  localparam int             ROWS    = 2 ** (PW - 1);
  localparam logic [PW-1:0]  CNT_MAX = PW'(QUEUE_DEPTH - 1);
  localparam logic [PW-1:0]  GREET_N = PW'(GREET_WORDS);

  // ---------------------------------------------------------------------
  // Handshake: input register and result register
  // ---------------------------------------------------------------------
  logic        in_valid_r;
  logic [1:0]  in_mode_r;
  logic [31:0] mail_r;
  logic        in_fire;
  logic        proc_fire;

  assign proc_fire = in_valid_r && (!out_valid || out_ready);
  assign in_ready  = !in_valid_r || proc_fire;
  assign in_fire   = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Command state
  // ---------------------------------------------------------------------
  logic [31:0] held_word_r, held_word_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic        booted_r, booted_nxt;
  logic [15:0] params_r, params_nxt;
  logic        await_r, await_nxt;
  logic [31:0] fw_r, fw_nxt;
  logic        fc_r, fc_nxt;
  logic        resume_r, resume_nxt;
  logic        test_r, test_nxt;

  // Queue state
  logic [PW-1:0]          wr_r, wr_nxt;
  logic [PW-1:0]          rd_r, rd_nxt;
  logic [PW-1:0]          cnt_r, cnt_nxt;
  logic [GREET_WORDS-1:0] greet_r, greet_nxt;

  // Two banks: even slots and odd slots
  logic [31:0] bank0 [ROWS];
  logic [31:0] bank1 [ROWS];
  logic [31:0] b0_q_r, b1_q_r;
  logic        head_bank_r;
  logic        alt_valid_r;
  logic [31:0] alt_data_r;
  logic [31:0] head_w;

  // Decode results
  mode_t       mode_e;
  logic [15:0] hi, lo;
  logic [31:0] fw_eff;
  logic        irq;
  logic [1:0]  push_cnt;
  logic [31:0] w0, w1;
  logic        boot;
  logic        pop_ok;
  logic [31:0] popped;
  logic [15:0] rdata;

  // Queue update
  logic [PW-1:0] base_wr, base_rd, base_cnt, cnt1;
  logic [PW-1:0] slot0, slot1, rd_a;
  logic          ok0, ok1, ovf;
  logic [PW-1:0] n_wr;
  logic          b0_we, b1_we;
  logic [PW-2:0] b0_waddr, b1_waddr;
  logic [31:0]   b0_wdata, b1_wdata;
  logic          fwd0, fwd1;
  logic [GREET_WORDS-1:0] greet_eff;
  logic          greet_hit;
  logic          alt_valid_nxt;
  logic [31:0]   alt_data_nxt;

  // Result register
  logic        out_valid_r;
  logic [15:0] out_rd_r;
  logic        out_irq_r, out_ovf_r, out_booted_r, out_waiting_r;

  assign mode_e = mode_t'(in_mode_r);
  assign hi     = mail_r[31:16];
  assign lo     = mail_r[15:0];

  // Head of queue as prefetched when this beat was taken in
  assign head_w = alt_valid_r ? alt_data_r : (head_bank_r ? b1_q_r : b0_q_r);
  assign pop_ok = (mode_e == MODE_RD_HI || mode_e == MODE_RD_LO) && !held_valid_r &&
                  (cnt_r != '0);
  assign popped = pop_ok ? head_w : 32'd0;

  // ---------------------------------------------------------------------
  // Command decode and read-out for the beat in the input register
  // ---------------------------------------------------------------------
  always_comb begin
    held_word_nxt  = held_word_r;
    held_valid_nxt = held_valid_r;
    booted_nxt     = booted_r;
    params_nxt     = params_r;
    await_nxt      = await_r;
    fw_nxt         = fw_r;
    fc_nxt         = fc_r;
    resume_nxt     = resume_r;
    test_nxt       = test_r;
    fw_eff         = fw_r;
    irq            = 1'b0;
    push_cnt       = 2'd0;
    w0             = 32'd0;
    w1             = 32'd0;
    boot           = 1'b0;
    rdata          = 16'd0;
    case (mode_e)
      MODE_SEND: begin
        held_valid_nxt = 1'b0;
        if (await_r) begin
          // vector word: boot only after the boot form
          if (fw_r[15:0] == CMD_BOOT) begin
            boot          = 1'b1;
            booted_nxt    = 1'b1;
            held_word_nxt = 32'd0;
            push_cnt      = 2'd2;
            w0            = MAIL_INIT;
            w1            = MAIL_RESUME;
          end
          await_nxt = 1'b0;
        end else if (params_r == 16'd0) begin
          if (mail_r == 32'd0) begin
            irq = 1'b1;
          end else if (hi == HI_NONE) begin
            params_nxt = lo;
          end else if (hi == HI_RESUME) begin
            params_nxt = PARAMS_RESUME;
            resume_nxt = 1'b1;
          end else if (hi == HI_TEST) begin
            params_nxt = PARAMS_TEST;
            test_nxt   = 1'b1;
          end else begin
            case (lo)
              CMD_RESUME_NOW: begin
                push_cnt = 2'd1;
                w0       = MAIL_RESUME;
                irq      = 1'b1;
              end
              CMD_RESUME_4: begin
                resume_nxt = 1'b1;
                fw_nxt     = mail_r;
                fc_nxt     = 1'b1;
                params_nxt = PARAMS_RES4;
              end
              CMD_SYNC_A, CMD_SYNC_B, CMD_SYNC_C, CMD_SYNC_D, CMD_SYNC_E,
              CMD_SYNC_F: begin
                fw_nxt     = mail_r;
                fc_nxt     = 1'b1;
                params_nxt = PARAMS_SYNC;
              end
              CMD_VEC_A, CMD_VEC_B, CMD_VEC_C, CMD_VEC_D, CMD_BOOT: begin
                fw_nxt    = mail_r;
                await_nxt = 1'b1;
              end
              default: begin
                // unknown form: drop
              end
            endcase
          end
        end else begin
          // parameter word
          if (!fc_r) begin
            fw_eff = mail_r;
          end
          fw_nxt     = fw_eff;
          fc_nxt     = 1'b1;
          params_nxt = params_r - 16'd1;
          if (params_r == 16'd1) begin
            fc_nxt = 1'b0;
            if (test_r) begin
              push_cnt = 2'd0;
            end else if (resume_r) begin
              push_cnt = 2'd1;
              w0       = MAIL_RESUME;
            end else begin
              push_cnt = 2'd2;
              w0       = MAIL_SYNC;
              w1       = SYNC_TAG | {16'd0, fw_eff[31:16]};
            end
            test_nxt   = 1'b0;
            resume_nxt = 1'b0;
          end
        end
      end
      MODE_RD_HI: begin
        if (!held_valid_r) begin
          held_word_nxt  = popped;
          held_valid_nxt = 1'b1;
        end
        rdata = held_word_nxt[31:16];
      end
      MODE_RD_LO: begin
        if (!held_valid_r) begin
          held_word_nxt = popped;
        end
        held_valid_nxt = 1'b0;
        rdata          = held_word_nxt[15:0];
      end
      MODE_TICK: begin
        irq = booted_r && (cnt_r != '0);
      end
      default: begin
        irq = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Reply queue: pushes, pop, forwarding for the next prefetch
  // ---------------------------------------------------------------------
  always_comb begin
    base_wr  = boot ? '0 : wr_r;
    base_rd  = boot ? '0 : rd_r;
    base_cnt = boot ? '0 : cnt_r;
    ok0      = (push_cnt != 2'd0) && (base_cnt != CNT_MAX);
    cnt1     = base_cnt + {{(PW-1){1'b0}}, ok0};
    ok1      = (push_cnt == 2'd2) && ok0 && (cnt1 != CNT_MAX);
    ovf      = ((push_cnt != 2'd0) && !ok0) || ((push_cnt == 2'd2) && !ok1);
    n_wr     = {{(PW-1){1'b0}}, ok0} + {{(PW-1){1'b0}}, ok1};
    slot0    = base_wr;
    slot1    = base_wr + {{(PW-1){1'b0}}, 1'b1};
    wr_nxt   = base_wr + n_wr;
    rd_nxt   = base_rd + {{(PW-1){1'b0}}, pop_ok};
    cnt_nxt  = base_cnt + n_wr - {{(PW-1){1'b0}}, pop_ok};

    // the two slots differ in parity, so each bank takes at most one write
    b0_we    = proc_fire && ((ok0 && !slot0[0]) || (ok1 && !slot1[0]));
    b1_we    = proc_fire && ((ok0 && slot0[0]) || (ok1 && slot1[0]));
    b0_waddr = slot0[0] ? slot1[PW-1:1] : slot0[PW-1:1];
    b1_waddr = slot0[0] ? slot0[PW-1:1] : slot1[PW-1:1];
    b0_wdata = slot0[0] ? w1 : w0;
    b1_wdata = slot0[0] ? w0 : w1;

    greet_nxt = greet_r;
    for (int i = 0; i < GREET_WORDS; i++) begin
      if ((ok0 && slot0 == PW'(i)) || (ok1 && slot1 == PW'(i))) begin
        greet_nxt[i] = 1'b0;
      end
    end

    // slot to prefetch for the beat taken in this cycle
    rd_a      = proc_fire ? rd_nxt : rd_r;
    greet_eff = proc_fire ? greet_nxt : greet_r;
    fwd0      = proc_fire && ok0 && (slot0 == rd_a);
    fwd1      = proc_fire && ok1 && (slot1 == rd_a);
    greet_hit = (rd_a < GREET_N) && greet_eff[rd_a[1:0]];
    alt_valid_nxt = fwd0 || fwd1 || greet_hit;
    if (fwd0) begin
      alt_data_nxt = w0;
    end else if (fwd1) begin
      alt_data_nxt = w1;
    end else begin
      alt_data_nxt = greet_word(rd_a[1:0]);
    end
  end

  // Bank storage with registered read
  always_ff @(posedge clk) begin
    if (b0_we) begin
      bank0[b0_waddr] <= b0_wdata;
    end
    if (in_fire) begin
      b0_q_r <= bank0[rd_a[PW-1:1]];
    end
  end

  always_ff @(posedge clk) begin
    if (b1_we) begin
      bank1[b1_waddr] <= b1_wdata;
    end
    if (in_fire) begin
      b1_q_r <= bank1[rd_a[PW-1:1]];
    end
  end

  // Payload registers: input beat and prefetch selection
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_mode_r   <= in_mode;
      mail_r      <= in_mail_word;
      head_bank_r <= rd_a[0];
      alt_valid_r <= alt_valid_nxt;
      alt_data_r  <= alt_data_nxt;
    end
    if (proc_fire) begin
      out_rd_r      <= rdata;
      out_irq_r     <= irq;
      out_ovf_r     <= ovf;
      out_booted_r  <= booted_nxt;
      out_waiting_r <= (cnt_nxt != '0);
    end
  end

  // Control and command state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      held_word_r  <= 32'd0;
      held_valid_r <= 1'b0;
      booted_r     <= 1'b0;
      params_r     <= 16'd0;
      await_r      <= 1'b0;
      fw_r         <= 32'd0;
      fc_r         <= 1'b0;
      resume_r     <= 1'b0;
      test_r       <= 1'b0;
      wr_r         <= GREET_N;
      rd_r         <= '0;
      cnt_r        <= GREET_N;
      greet_r      <= '1;
    end else begin
      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (proc_fire) begin
        in_valid_r <= 1'b0;
      end
      if (proc_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (proc_fire) begin
        held_word_r  <= held_word_nxt;
        held_valid_r <= held_valid_nxt;
        booted_r     <= booted_nxt;
        params_r     <= params_nxt;
        await_r      <= await_nxt;
        fw_r         <= fw_nxt;
        fc_r         <= fc_nxt;
        resume_r     <= resume_nxt;
        test_r       <= test_nxt;
        wr_r         <= wr_nxt;
        rd_r         <= rd_nxt;
        cnt_r        <= cnt_nxt;
        greet_r      <= greet_nxt;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_rd_r;
  assign out_raise_interrupt = out_irq_r;
  assign out_overflow        = out_ovf_r;
  assign out_booted          = out_booted_r;
  assign out_replies_waiting = out_waiting_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `DMCR_ASSERT_ALWAYS(a_cnt_range, cnt_r <= CNT_MAX, "reply queue count above capacity")
  `DMCR_ASSERT_ALWAYS(a_ptr_cnt, (wr_r - rd_r) == cnt_r, "queue pointers disagree with count")
  `DMCR_ASSERT_IMPLIES(a_ovf_full, proc_fire && ovf,
    !boot && (cnt_r == CNT_MAX || cnt_r == CNT_MAX - PW'(1)), "drop without full queue")
  `DMCR_ASSERT_NEXT(a_boot, proc_fire && boot,
    booted_r && !held_valid_r && rd_r == '0, "boot did not reset the queue")
  `DMCR_ASSERT_IMPLIES(a_pop_push, proc_fire && pop_ok, push_cnt == 2'd0,
    "pop and push in one beat")

endmodule

@@ tb/dsp_mailbox_command_responder_unit_tb.sv @@
// Self-checking testbench for the DSP mailbox command responder.
module dsp_mailbox_command_responder_unit_tb;
  import dmcr_pkg::*;

  localparam int QUEUE_DEPTH   = 16;
  localparam int RESET_CYCLES  = 10;
  localparam int ITEM_COUNT    = 1950;
  // No idling once this few beats are left to send
  localparam int CALM_TAIL     = 150;
  // Leave a margin for the tail of the run
  localparam int SETTLE_CYCLES = 12;
  // Correct quiet spells come from send gaps, sink stalls and the result path
  localparam int STALL_LIMIT   = 1000;

  typedef struct {
    mode_t       mode;
    logic [31:0] word;
    bit          drain;   // hold this beat back until every result is in
  } mail_beat_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        raise_interrupt;
    logic        overflow;
    logic        booted;
    logic        replies_waiting;
  } response_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_SEND;
  logic [31:0] in_mail_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_read_data;
  logic        out_raise_interrupt;
  logic        out_overflow;
  logic        out_booted;
  logic        out_replies_waiting;

  mail_beat_t  pending_beats[$];
  response_t   expected_replies[$];
  int unsigned beats_accepted = 0;
  int unsigned total_beats = 0;
  int unsigned errors = 0;
  int unsigned stall_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned sink_gap = 0;
  bit          send_quiet = 1'b0;
  bit          sink_quiet = 1'b0;

  // Mirror of the responder's state
  logic [31:0] reply_mem [QUEUE_DEPTH];
  int          reply_wr;
  int          reply_rd;
  logic [31:0] latched_reply;
  bit          latched_ok;
  bit          dsp_booted;
  bit          vector_due;
  logic [15:0] params_due;
  logic [31:0] cmd_word;
  bit          cmd_held;
  bit          resume_due;
  bit          test_due;

  dsp_mailbox_command_responder_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_mail_word       (in_mail_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_raise_interrupt(out_raise_interrupt),
    .out_overflow       (out_overflow),
    .out_booted         (out_booted),
    .out_replies_waiting(out_replies_waiting)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Push a reply word; return 1 when the queue is full and the word is dropped.
  function automatic bit reply_push(input logic [31:0] w);
    int nx;
    nx = (reply_wr + 1) % QUEUE_DEPTH;
    if (nx == reply_rd) return 1'b1;
    reply_mem[reply_wr] = w;
    reply_wr = nx;
    return 1'b0;
  endfunction

  // Pop a reply word; an empty queue yields zero and leaves the pointers alone.
  function automatic logic [31:0] reply_pop();
    logic [31:0] w;
    if (reply_wr == reply_rd) return '0;
    w = reply_mem[reply_rd];
    reply_rd = (reply_rd + 1) % QUEUE_DEPTH;
    return w;
  endfunction

  // Advance the mirrored state by one accepted beat and return its result.
  function automatic response_t compute_response(input mode_t mode, input logic [31:0] m);
    response_t   r;
    logic [15:0] hi;
    logic [15:0] lo;
    hi = m[31:16];
    lo = m[15:0];
    r  = '0;
    case (mode)
      MODE_SEND: begin
        latched_ok = 1'b0;
        if (vector_due) begin
          // Only the boot form acts on its vector word: restart the queue
          if (cmd_word[15:0] == CMD_BOOT) begin
            dsp_booted    = 1'b1;
            reply_wr      = 0;
            reply_rd      = 0;
            latched_reply = '0;
            latched_ok    = 1'b0;
            r.overflow |= reply_push(MAIL_INIT);
            r.overflow |= reply_push(MAIL_RESUME);
          end
          vector_due = 1'b0;
        end else if (params_due == 16'd0) begin
          if (m == 32'd0) begin
            r.raise_interrupt = 1'b1;
          end else if (hi == HI_NONE) begin
            params_due = lo;
          end else if (hi == HI_RESUME) begin
            params_due = PARAMS_RESUME;
            resume_due = 1'b1;
          end else if (hi == HI_TEST) begin
            params_due = PARAMS_TEST;
            test_due   = 1'b1;
          end else begin
            case (lo)
              CMD_RESUME_NOW: begin
                r.overflow |= reply_push(MAIL_RESUME);
                r.raise_interrupt = 1'b1;
              end
              CMD_RESUME_4: begin
                resume_due = 1'b1;
                cmd_word   = m;
                cmd_held   = 1'b1;
                params_due = PARAMS_RES4;
              end
              CMD_SYNC_A, CMD_SYNC_B, CMD_SYNC_C, CMD_SYNC_D, CMD_SYNC_E, CMD_SYNC_F: begin
                cmd_word   = m;
                cmd_held   = 1'b1;
                params_due = PARAMS_SYNC;
              end
              CMD_VEC_A, CMD_VEC_B, CMD_VEC_C, CMD_VEC_D, CMD_BOOT: begin
                cmd_word   = m;
                vector_due = 1'b1;
              end
              default: ;
            endcase
          end
        end else begin
          // Parameter word: the first one tags the reply unless the command did
          if (!cmd_held) begin
            cmd_word = m;
            cmd_held = 1'b1;
          end
          params_due = params_due - 16'd1;
          if (params_due == 16'd0) begin
            cmd_held = 1'b0;
            if (!test_due) begin
              if (resume_due) begin
                r.overflow |= reply_push(MAIL_RESUME);
              end else begin
                r.overflow |= reply_push(MAIL_SYNC);
                r.overflow |= reply_push(SYNC_TAG | {16'h0000, cmd_word[31:16]});
              end
            end
            test_due   = 1'b0;
            resume_due = 1'b0;
          end
        end
      end
      MODE_RD_HI: begin
        if (!latched_ok) begin
          latched_reply = reply_pop();
          latched_ok    = 1'b1;
        end
        r.read_data = latched_reply[31:16];
      end
      MODE_RD_LO: begin
        if (!latched_ok) latched_reply = reply_pop();
        latched_ok  = 1'b0;
        r.read_data = latched_reply[15:0];
      end
      default: begin
        if (dsp_booted && reply_wr != reply_rd) r.raise_interrupt = 1'b1;
      end
    endcase
    r.booted          = dsp_booted;
    r.replies_waiting = (reply_wr != reply_rd);
    return r;
  endfunction

  task automatic add_beat(input mode_t mode, input logic [31:0] word, input bit drain = 1'b0);
    mail_beat_t b;
    b.mode  = mode;
    b.word  = word;
    b.drain = drain;
    pending_beats.push_back(b);
  endtask

  // Upper half that selects a lower-half command form
  function automatic logic [15:0] random_upper();
    logic [15:0] u;
    u = 16'($urandom());
    while (u == HI_NONE || u == HI_RESUME || u == HI_TEST) u = 16'($urandom());
    return u;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endtask

  // Driver: feed beats from the pending queue, predicting each one as it is accepted.
  always @(posedge clk) begin : drive_beats
    mail_beat_t nxt;
    logic       load;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_replies.push_back(compute_response(mode_t'(in_mode), in_mail_word));
        beats_accepted++;
      end
      // Hold the payload while a beat is offered and not yet taken
      if (!in_valid || in_ready) begin
        load = 1'b0;
        if ($urandom_range(0, 39) == 0) send_quiet = ~send_quiet;
        if (send_gap == 0 && !send_quiet && pending_beats.size() > CALM_TAIL &&
            $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 3);
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].drain && expected_replies.size() != 0)) begin
          nxt = pending_beats.pop_front();
          in_mode      <= nxt.mode;
          in_mail_word <= nxt.word;
          load = 1'b1;
        end
        in_valid <= load;
      end
    end
  end

  // Monitor: compare every result beat with the oldest prediction, stall at random.
  always @(posedge clk) begin : check_beats
    response_t want;
    logic      rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: result beat with nothing expected, got read_data %h irq %b",
                   $time, out_read_data, out_raise_interrupt);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          check_field("read_data", want.read_data, out_read_data);
          check_field("raise_interrupt", 16'(want.raise_interrupt), 16'(out_raise_interrupt));
          check_field("overflow", 16'(want.overflow), 16'(out_overflow));
          check_field("booted", 16'(want.booted), 16'(out_booted));
          check_field("replies_waiting", 16'(want.replies_waiting),
                      16'(out_replies_waiting));
        end
      end
      rdy = 1'b1;
      if ($urandom_range(0, 59) == 0) sink_quiet = ~sink_quiet;
      if (sink_gap == 0 && !sink_quiet && pending_beats.size() > CALM_TAIL &&
          $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 3);
      if (sink_gap > 0) begin
        sink_gap--;
        rdy = 1'b0;
      end
      out_ready <= rdy;
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : run
    int unsigned read_bias;
    int unsigned pick;
    int unsigned n;
    logic [15:0] lo;

    // Reset image of the mirror: three greeting words queued
    for (int i = 0; i < QUEUE_DEPTH; i++) reply_mem[i] = '0;
    reply_mem[0]  = GREET_0;
    reply_mem[1]  = GREET_1;
    reply_mem[2]  = GREET_2;
    reply_wr      = GREET_WORDS;
    reply_rd      = 0;
    latched_reply = '0;
    latched_ok    = 1'b0;
    dsp_booted    = 1'b0;
    vector_due    = 1'b0;
    params_due    = '0;
    cmd_word      = '0;
    cmd_held      = 1'b0;
    resume_due    = 1'b0;
    test_due      = 1'b0;

    // Directed: drain the greetings, hit the empty-queue read and the command shapes other than test and resume-4
    add_beat(MODE_RD_HI, 32'h0000_0000);
    add_beat(MODE_RD_LO, 32'hFFFF_FFFF);
    add_beat(MODE_RD_HI, 32'h0000_0000);
    add_beat(MODE_RD_HI, 32'hFFFF_FFFF);    // held reply read again
    add_beat(MODE_RD_LO, 32'h0000_0000);
    add_beat(MODE_RD_LO, 32'h0000_0000);    // low half without a high half first
    add_beat(MODE_RD_LO, 32'h0000_0000);    // empty queue reads zero
    add_beat(MODE_TICK,  32'hFFFF_FFFF);    // not booted: no interrupt
    add_beat(MODE_SEND,  32'h0000_0000);    // zero word raises the interrupt
    add_beat(MODE_SEND,  32'hFFFF_FFFF);    // unknown form, ignored
    add_beat(MODE_SEND,  {16'hFFFF, CMD_RESUME_NOW});
    add_beat(MODE_SEND,  {HI_RESUME, 16'hFFFF});
    add_beat(MODE_SEND,  32'hFFFF_FFFF);
    add_beat(MODE_SEND,  32'h0000_0001);    // explicit count of one
    add_beat(MODE_SEND,  32'h0000_0000);
    add_beat(MODE_SEND,  {16'h8000, CMD_SYNC_B});
    add_beat(MODE_SEND,  32'h0000_0001);
    add_beat(MODE_SEND,  32'h0000_0002);
    add_beat(MODE_SEND,  {16'h1234, CMD_VEC_A});
    add_beat(MODE_SEND,  32'hDEAD_BEEF);    // vector word of a non-boot form
    add_beat(MODE_SEND,  {16'h5A5A, CMD_BOOT});
    add_beat(MODE_SEND,  32'hFFFF_FFFF);    // boot
    add_beat(MODE_TICK,  32'h0000_0000, 1'b1);
    add_beat(MODE_RD_HI, 32'h0000_0000);
    add_beat(MODE_RD_LO, 32'h0000_0000);

    // Random: mostly well-formed commands, reads weighted by phase so that the
    // queue both fills to overflow and runs dry
    read_bias = 1;
    while (pending_beats.size() < ITEM_COUNT) begin
      if ($urandom_range(0, 59) == 0) read_bias = $urandom_range(0, 3);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        add_beat(mode_t'($urandom_range(0, 3)), $urandom());
      end else if (pick < 8 + 12 * read_bias) begin
        case ($urandom_range(0, 3))
          0: add_beat(MODE_RD_HI, $urandom());
          1: add_beat(MODE_RD_LO, $urandom());
          default: begin
            add_beat(MODE_RD_HI, $urandom());
            add_beat(MODE_RD_LO, $urandom());
          end
        endcase
      end else if (pick < 14 + 12 * read_bias) begin
        add_beat(MODE_TICK, $urandom());
      end else begin
        case ($urandom_range(0, 15))
          0: add_beat(MODE_SEND, 32'h0000_0000);
          1, 2, 3: add_beat(MODE_SEND, {random_upper(), CMD_RESUME_NOW});
          4: begin
            add_beat(MODE_SEND, {HI_RESUME, 16'($urandom())});
            add_beat(MODE_SEND, $urandom());
          end
          5: begin
            add_beat(MODE_SEND, {HI_TEST, 16'($urandom())});
            repeat (PARAMS_TEST) add_beat(MODE_SEND, $urandom());
          end
          6: begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            add_beat(MODE_SEND, {HI_NONE, 16'(n)});
            repeat (n) add_beat(MODE_SEND, $urandom());
          end
          7, 8, 9, 10: begin
            case ($urandom_range(0, 5))
              0: lo = CMD_SYNC_A;
              1: lo = CMD_SYNC_B;
              2: lo = CMD_SYNC_C;
              3: lo = CMD_SYNC_D;
              4: lo = CMD_SYNC_E;
              default: lo = CMD_SYNC_F;
            endcase
            add_beat(MODE_SEND, {random_upper(), lo});
            repeat (PARAMS_SYNC) add_beat(MODE_SEND, $urandom());
          end
          11: begin
            add_beat(MODE_SEND, {random_upper(), CMD_RESUME_4});
            repeat (PARAMS_RES4) add_beat(MODE_SEND, $urandom());
          end
          12: begin
            case ($urandom_range(0, 3))
              0: lo = CMD_VEC_A;
              1: lo = CMD_VEC_B;
              2: lo = CMD_VEC_C;
              default: lo = CMD_VEC_D;
            endcase
            add_beat(MODE_SEND, {random_upper(), lo});
            add_beat(MODE_SEND, $urandom());
          end
          13: begin
            // Boot resets the queue to its two boot replies, so keep it rare
            if ($urandom_range(0, 2) == 0) begin
              add_beat(MODE_SEND, {random_upper(), CMD_BOOT});
              add_beat(MODE_SEND, $urandom());
            end else begin
              add_beat(MODE_SEND, {random_upper(), CMD_RESUME_NOW});
            end
          end
          default: add_beat(MODE_SEND, {random_upper(), 16'($urandom())});
        endcase
      end
      // Pause the sender once mid-run until every result has come back
      if (pending_beats.size() >= ITEM_COUNT / 2 && pending_beats.size() < ITEM_COUNT / 2 + 8)
        pending_beats[pending_beats.size() - 1].drain = 1'b1;
    end
    total_beats = pending_beats.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_accepted < total_beats || expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0 && expected_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
